// ----- hw/rtl/dcq_pkg.sv -----
// dcq_pkg: shared types, widths, codes and the reciprocal table of the
// 3d dct coefficient quantizer. no dependencies.
`default_nettype none
package dcq_pkg;

    localparam int CUBE_SIZE_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int COEF_W      = 24;
    localparam int VALUE_W     = 32;
    localparam int STEP_W      = 6;   // step up to 34 for the largest cube
    localparam int SUM_W       = 7;   // holds 2*(x+y+z) for the largest cube
    localparam int MAG_W       = 16;  // |coefficient| with fraction bits dropped
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 20;
    localparam int QUOT_W      = 14;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic MODE_QUANT   = 1'b0;
    localparam logic MODE_DEQUANT = 1'b1;

    localparam logic REG_MODE = 1'b0;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [STEP_W-1:0]        step;
        logic                     mode;
        logic                     last;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // floor(2^20 / step) for every step the position counters can give
    function automatic logic [RECIP_W-1:0] recip_of(input logic [STEP_W-1:0] step);
        logic [RECIP_W-1:0] r;
        case (step)
            6'd4:    r = 19'd262144;
            6'd5:    r = 19'd209715;
            6'd6:    r = 19'd174762;
            6'd7:    r = 19'd149796;
            6'd8:    r = 19'd131072;
            6'd9:    r = 19'd116508;
            6'd10:   r = 19'd104857;
            6'd11:   r = 19'd95325;
            6'd12:   r = 19'd87381;
            6'd13:   r = 19'd80659;
            6'd14:   r = 19'd74898;
            6'd15:   r = 19'd69905;
            6'd16:   r = 19'd65536;
            6'd17:   r = 19'd61680;
            6'd18:   r = 19'd58254;
            6'd19:   r = 19'd55188;
            6'd20:   r = 19'd52428;
            6'd21:   r = 19'd49932;
            6'd22:   r = 19'd47662;
            6'd23:   r = 19'd45590;
            6'd24:   r = 19'd43690;
            6'd25:   r = 19'd41943;
            6'd26:   r = 19'd40329;
            6'd27:   r = 19'd38836;
            6'd28:   r = 19'd37449;
            6'd29:   r = 19'd36157;
            6'd30:   r = 19'd34952;
            6'd31:   r = 19'd33825;
            6'd32:   r = 19'd32768;
            6'd33:   r = 19'd31775;
            6'd34:   r = 19'd30840;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dcq_front.sv -----
// dcq_front: takes coefficient words, tracks the cube position and
// works out step and last flag for each word. depends on dcq_pkg.
`default_nettype none
module dcq_front #(
    parameter int CUBE_SIZE = dcq_pkg::CUBE_SIZE_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic signed [dcq_pkg::COEF_W-1:0] i_coefficient,
    input  wire logic                              i_mode,
    input  wire dcq_pkg::t_queue_status            i_q_stat,
    output      logic                              o_ready,
    output      logic                              o_push,
    output      dcq_pkg::t_item                    o_item
);

    localparam int POS_W = (CUBE_SIZE > 1) ? $clog2(CUBE_SIZE) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(CUBE_SIZE - 1);

    logic [POS_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [POS_W-1:0] n_pos_x, n_pos_y, n_pos_z;

    logic [dcq_pkg::SUM_W-1:0]  w_sum;
    logic [dcq_pkg::SUM_W-1:0]  w_twice;
    logic [dcq_pkg::SUM_W+7:0]  w_third_prod;
    logic [dcq_pkg::STEP_W-1:0] w_third;
    logic                       w_end_x, w_end_y, w_end_z;

    assign w_end_x = (r_pos_x == LAST_POS);
    assign w_end_y = (r_pos_y == LAST_POS);
    assign w_end_z = (r_pos_z == LAST_POS);

    // floor(n/3) as (n*171)>>9, exact for n below 256
    assign w_sum        = dcq_pkg::SUM_W'(r_pos_x) + dcq_pkg::SUM_W'(r_pos_y)
                        + dcq_pkg::SUM_W'(r_pos_z);
    assign w_twice      = w_sum << 1;
    assign w_third_prod = (dcq_pkg::SUM_W+8)'(w_twice) * (dcq_pkg::SUM_W+8)'(171);
    assign w_third      = w_third_prod[dcq_pkg::SUM_W+7 -: dcq_pkg::STEP_W];

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    always_comb begin
        o_item.coefficient = i_coefficient;
        o_item.step        = dcq_pkg::STEP_W'(4) + w_third;
        o_item.mode        = i_mode;
        o_item.last        = w_end_x && w_end_y && w_end_z;
    end

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        if (o_push) begin
            n_pos_x = w_end_x ? '0 : r_pos_x + 1'b1;
            if (w_end_x) begin
                n_pos_y = w_end_y ? '0 : r_pos_y + 1'b1;
                if (w_end_y) begin
                    n_pos_z = w_end_z ? '0 : r_pos_z + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
        end else begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/dcq_queue.sv -----
// dcq_queue: short first-in first-out buffer of classified words between
// the front and the arithmetic back end. depends on dcq_pkg.
`default_nettype none
module dcq_queue #(
    parameter int DEPTH = dcq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire dcq_pkg::t_item         i_item,
    input  wire logic                   i_pop,
    output      dcq_pkg::t_item         o_item,
    output      dcq_pkg::t_queue_status o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dcq_pkg::t_item r_mem [DEPTH];
    dcq_pkg::t_item r_head;

    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_item       = r_head;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_wr_ptr = i_push ? bump(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? bump(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // head word held in a register, taken straight from the input when it lands at the head
    always_ff @(posedge i_clk) begin
        if (i_push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_item;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/dcq_back.sv -----
// dcq_back: four-stage arithmetic pipe, reciprocal divide for quantize and
// scaled saturating multiply for dequantize, with the output register. depends on dcq_pkg.
`default_nettype none
module dcq_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire dcq_pkg::t_item                     i_item,
    input  wire dcq_pkg::t_queue_status             i_q_stat,
    output      logic                               o_pop,
    output      logic                               o_valid,
    input  wire logic                               i_ready,
    output      logic signed [dcq_pkg::VALUE_W-1:0] o_value,
    output      logic                               o_last_of_block
);

    localparam int COEF_W  = dcq_pkg::COEF_W;
    localparam int STEP_W  = dcq_pkg::STEP_W;
    localparam int MAG_W   = dcq_pkg::MAG_W;
    localparam int RECIP_W = dcq_pkg::RECIP_W;
    localparam int QUOT_W  = dcq_pkg::QUOT_W;
    localparam int QP_W    = MAG_W + RECIP_W;
    localparam int QM_W    = QUOT_W + STEP_W;
    localparam int DP_W    = COEF_W + STEP_W + 1;
    localparam int VALUE_W = dcq_pkg::VALUE_W;

    localparam logic signed [DP_W-1:0] DP_MAX = DP_W'((1 <<< 23) - 1);
    localparam logic signed [DP_W-1:0] DP_MIN = -DP_W'(1 <<< 23);

    logic w_en;

    // stage 1
    logic                       r_s1_vld;
    logic                       r_s1_mode, r_s1_neg, r_s1_last;
    logic [MAG_W-1:0]           r_s1_mag;
    logic [RECIP_W-1:0]         r_s1_recip;
    logic [STEP_W-1:0]          r_s1_step;
    logic signed [COEF_W-1:0]   r_s1_coef;
    logic [COEF_W-1:0]          w_abs;

    // stage 2
    logic                       r_s2_vld;
    logic                       r_s2_mode, r_s2_neg, r_s2_last;
    logic [MAG_W-1:0]           r_s2_mag;
    logic [STEP_W-1:0]          r_s2_step;
    logic [QP_W-1:0]            r_s2_qprod;
    logic signed [DP_W-1:0]     r_s2_dprod;
    logic [QUOT_W-1:0]          w_q0;

    // stage 3
    logic                       r_s3_vld;
    logic                       r_s3_mode, r_s3_neg, r_s3_last;
    logic [MAG_W-1:0]           r_s3_mag;
    logic [STEP_W-1:0]          r_s3_step;
    logic [QUOT_W-1:0]          r_s3_q0;
    logic [QM_W-1:0]            r_s3_qm;
    logic signed [VALUE_W-1:0]  r_s3_deq;
    logic [MAG_W-1:0]           w_rem;
    logic [QUOT_W-1:0]          w_quot;
    logic [VALUE_W-1:0]         w_quot_ext;

    logic                       r_out_vld;
    logic signed [VALUE_W-1:0]  r_out_value;
    logic                       r_out_last;

    // whole pipe moves when the output register is free or being taken
    assign w_en  = !r_out_vld || i_ready;
    assign o_pop = w_en && !i_q_stat.empty;

    // -(-2^23) still fits as an unsigned 24-bit magnitude
    assign w_abs = i_item.coefficient[COEF_W-1] ? COEF_W'(-i_item.coefficient)
                                                : COEF_W'(i_item.coefficient);

    assign w_q0 = r_s2_qprod[dcq_pkg::RECIP_SHIFT +: QUOT_W];

    // reciprocal estimate is low by at most one
    assign w_rem      = r_s3_mag - MAG_W'(r_s3_qm);
    assign w_quot     = (w_rem >= MAG_W'(r_s3_step)) ? r_s3_q0 + 1'b1 : r_s3_q0;
    assign w_quot_ext = VALUE_W'(w_quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= !i_q_stat.empty;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_mode  <= i_item.mode;
            r_s1_neg   <= i_item.coefficient[COEF_W-1];
            r_s1_last  <= i_item.last;
            r_s1_mag   <= w_abs[COEF_W-1 -: MAG_W];
            r_s1_recip <= dcq_pkg::recip_of(i_item.step);
            r_s1_step  <= i_item.step;
            r_s1_coef  <= i_item.coefficient;

            r_s2_mode  <= r_s1_mode;
            r_s2_neg   <= r_s1_neg;
            r_s2_last  <= r_s1_last;
            r_s2_mag   <= r_s1_mag;
            r_s2_step  <= r_s1_step;
            r_s2_qprod <= QP_W'(r_s1_mag) * QP_W'(r_s1_recip);
            r_s2_dprod <= DP_W'(r_s1_coef) * $signed(DP_W'({1'b0, r_s1_step}));

            r_s3_mode  <= r_s2_mode;
            r_s3_neg   <= r_s2_neg;
            r_s3_last  <= r_s2_last;
            r_s3_mag   <= r_s2_mag;
            r_s3_step  <= r_s2_step;
            r_s3_q0    <= w_q0;
            r_s3_qm    <= QM_W'(w_q0) * QM_W'(r_s2_step);
            if (r_s2_dprod > DP_MAX) begin
                r_s3_deq <= {1'b0, {(VALUE_W-1){1'b1}}};
            end else if (r_s2_dprod < DP_MIN) begin
                r_s3_deq <= {1'b1, {(VALUE_W-1){1'b0}}};
            end else begin
                r_s3_deq <= {r_s2_dprod[COEF_W-1:0], 8'b0};
            end

            r_out_last <= r_s3_last;
            if (r_s3_mode == dcq_pkg::MODE_DEQUANT) begin
                r_out_value <= r_s3_deq;
            end else begin
                r_out_value <= r_s3_neg ? -$signed(w_quot_ext) : $signed(w_quot_ext);
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_value         = r_out_value;
    assign o_last_of_block = r_out_last;

endmodule
`default_nettype wire

// ----- hw/rtl/dct3d_coefficient_quantizer_unit.sv -----
// 3d dct coefficient quantizer: sustains one coefficient word per clock while the output
// is taken. each accepted word goes through the queue and then the four-register arithmetic
// pipe (magnitude and reciprocal lookup, reciprocal multiply, remainder multiply,
// correction into the output register). a stalled output freezes the pipe while a
// four-entry queue keeps taking words, so input ready drops only once that queue is
// full. the step follows a position counter that runs x fastest, then y, then z, and
// wraps after the last word of each cube; the mode register at byte address 0 should
// be written only while the block is empty.
// depends on dcq_pkg, dcq_front, dcq_queue, dcq_back.
`default_nettype none
module dct3d_coefficient_quantizer_unit #(
    parameter int CUBE_SIZE   = dcq_pkg::CUBE_SIZE_DEF,
    parameter int QUEUE_DEPTH = dcq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_ready,
    input  wire logic signed [dcq_pkg::COEF_W-1:0]  i_coefficient,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    output      logic signed [dcq_pkg::VALUE_W-1:0] o_value,
    output      logic                               o_last_of_block,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dcq_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [dcq_pkg::DATA_W-1:0]         pwdata,
    output      logic [dcq_pkg::DATA_W-1:0]         prdata,
    output      logic                               pready
);

    logic                   r_mode;
    logic                   w_cfg_wr;
    logic                   w_reg_idx;
    logic                   w_push, w_pop;
    dcq_pkg::t_item         w_push_item, w_head_item;
    dcq_pkg::t_queue_status w_q_stat;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= dcq_pkg::MODE_QUANT;
        end else if (w_cfg_wr && (w_reg_idx == dcq_pkg::REG_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_idx == dcq_pkg::REG_MODE) begin
            prdata[0] = r_mode;
        end
    end

    dcq_front #(
        .CUBE_SIZE (CUBE_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_coefficient (i_coefficient),
        .i_mode        (r_mode),
        .i_q_stat      (w_q_stat),
        .o_ready       (o_in_ready),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    dcq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_stat  (w_q_stat)
    );

    dcq_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (w_head_item),
        .i_q_stat        (w_q_stat),
        .o_pop           (w_pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_value         (o_value),
        .o_last_of_block (o_last_of_block)
    );

    // no word lost when the queue is full, none invented from an empty one
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("push into full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    a_mode_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cfg_wr |=> $stable(r_mode))
        else $error("mode changed without a register write");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule
`default_nettype wire
